>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the sorter back end (isort_back). Empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> hw/rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types for the insertion sorter.
// ----------------------------------------------------------------------------
package isort_pkg;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      ST_INSERT,
      ST_EMIT
   } back_state_type;

endpackage

>>> hw/rtl/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter
// Collects signed values into a sorted row and emits it on the last beat.
// ----------------------------------------------------------------------------
// An input beat is inserted by a row of compare-and-shift slots; a two-entry
// queue buffers input while the row is busy. A beat marked last starts
// emission: one output beat per cycle per stored value while rsp_stall is low,
// then a row clear; the back end takes no input until it is done. Values
// beyond CAPACITY are dropped and flag overflow on every beat of that set.
module insertion_sorter #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_value_res,
   output logic                  rsp_last_res,
   output logic                  rsp_overflow
);
   import isort_pkg::*;

   logic                  q_valid, q_take, q_last;
   logic [DATA_WIDTH-1:0] q_value;

   // Front end: input queue.
   isort_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_value, .req_last,
      .q_valid, .q_take, .q_value, .q_last
   );

   // Back end: sorted row and emitter.
   isort_back #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_value, .q_last,
      .rsp_valid, .rsp_stall, .rsp_value_res, .rsp_last_res, .rsp_overflow
   );
endmodule

>>> hw/rtl/isort_front.sv
// ----------------------------------------------------------------------------
// isort_front
// Accepts input beats and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module isort_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  logic                  req_last,
   output logic                  q_valid,
   input  logic                  q_take,
   output logic [DATA_WIDTH-1:0] q_value,
   output logic                  q_last
);
   import isort_pkg::*;

   logic [DATA_WIDTH:0] mem_ff [2];
   logic                wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                push, pop;

   // Queue control: the queue stalls the input when both entries are in use.
   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_take && q_valid;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_value   = mem_ff[rp_ff][DATA_WIDTH-1:0];
   assign q_last    = mem_ff[rp_ff][DATA_WIDTH];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= {req_last, req_value};
      end
   end
endmodule

>>> hw/rtl/isort_back.sv
// ----------------------------------------------------------------------------
// isort_back
// Inserts values into a sorted register row and streams it out on a last beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module isort_back #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   input  logic [DATA_WIDTH-1:0] q_value,
   input  logic                  q_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_value_res,
   output logic                  rsp_last_res,
   output logic                  rsp_overflow
);
   import isort_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   back_state_type        state_ff, state_in;
   logic [DATA_WIDTH-1:0] row_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] row_in [CAPACITY];
   logic [CW-1:0]         cnt_ff, cnt_in, idx_ff, idx_in;
   logic                  ovf_ff, ovf_in;
   logic                  ov_ff, ov_in;
   logic [DATA_WIDTH-1:0] ov_val_ff, ov_val_in;
   logic                  ov_last_ff, ov_last_in;
   logic                  ov_ovf_ff, ov_ovf_in;
   logic [CAPACITY-1:0]   gt;
   logic                  full, out_free;

   assign full     = (cnt_ff == CW'(CAPACITY));
   assign out_free = !ov_ff || !rsp_stall;
   assign q_take   = (state_ff == ST_INSERT);

   // Each slot compares its own value with the incoming one.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i] = ($signed(row_ff[i]) > $signed(q_value)) && (CW'(i) < cnt_ff);
      end
   end

   // Sequencer and slot updates.
   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      ovf_in     = ovf_ff;
      ov_in      = ov_ff && rsp_stall;
      ov_val_in  = ov_val_ff;
      ov_last_in = ov_last_ff;
      ov_ovf_in  = ov_ovf_ff;
      unique case (state_ff)
         ST_INSERT: begin
            if (q_valid) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (gt[i]) begin
                        row_in[i] = (i == 0) ? q_value : (gt[i-1] ? row_ff[i-1] : q_value);
                     end else if (CW'(i) == cnt_ff) begin
                        row_in[i] = (i == 0) ? q_value : (gt[i-1] ? row_ff[i-1] : q_value);
                     end
                  end
                  cnt_in = cnt_ff + CW'(1);
               end
               if (q_last) begin
                  state_in = ST_EMIT;
                  idx_in   = '0;
                  if (full) ovf_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (idx_ff == cnt_ff) begin
               state_in = ST_INSERT;
               cnt_in   = '0;
               ovf_in   = 1'b0;
            end else if (out_free) begin
               ov_in      = 1'b1;
               ov_val_in  = row_ff[idx_ff[IW-1:0]];
               ov_last_in = (idx_ff + CW'(1) == cnt_ff);
               ov_ovf_in  = ovf_ff;
               idx_in     = idx_ff + CW'(1);
            end
         end
         default: state_in = ST_INSERT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INSERT;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         ovf_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         ovf_ff   <= ovf_in;
         ov_ff    <= ov_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      ov_val_ff  <= ov_val_in;
      ov_last_ff <= ov_last_in;
      ov_ovf_ff  <= ov_ovf_in;
   end

   assign rsp_valid     = ov_ff;
   assign rsp_value_res = ov_val_ff;
   assign rsp_last_res  = ov_last_ff;
   assign rsp_overflow  = ov_ovf_ff;

   `ASSERT_IMPLIES(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CW'(CAPACITY))
   `ASSERT_IMPLIES(a_idx_range, clock, reset, state_ff == ST_EMIT, idx_ff <= cnt_ff)
   `ASSERT_NEXT(a_hold, clock, reset, ov_ff && rsp_stall, ov_ff && $stable(ov_val_ff))
endmodule

>>> tb/tb_insertion_sorter.sv
// ----------------------------------------------------------------------------
// tb_insertion_sorter
// Self-checking bench for the insertion sorter: sets of signed values are
// offered in bursts with random gaps, a sorting predictor computes the beats
// each set should emit, and every output beat is checked field by field.
// ----------------------------------------------------------------------------

// Holds the open set and the queue of sorted beats still awaited.
class sort_scoreboard;
   typedef struct packed {
      logic [31:0] value;
      logic        last_flag;
      logic        dropped;
   } sorted_beat_type;

   logic [31:0]     open_set[$];
   bit              set_dropped;
   sorted_beat_type awaited[$];
   int              error_count;

   function new();
      error_count = 0;
      set_dropped = 0;
   endfunction

   // Notes one accepted input beat and, on a last beat, queues the sorted set.
   function void note_input(logic [31:0] value, logic last_flag);
      int              pos;
      sorted_beat_type b;
      if (open_set.size() >= 16) begin
         set_dropped = 1;
      end else begin
         pos = open_set.size();
         while (pos > 0 && $signed(open_set[pos-1]) > $signed(value))
            pos--;
         open_set.insert(pos, value);
      end
      if (last_flag) begin
         foreach (open_set[k]) begin
            b.value     = open_set[k];
            b.last_flag = (k == open_set.size() - 1);
            b.dropped   = set_dropped;
            awaited.push_back(b);
         end
         open_set.delete();
         set_dropped = 0;
      end
   endfunction

   function void report(string what);
      $display("mismatch: %s", what);
      error_count++;
   endfunction

   // Compares one output beat with the oldest awaited beat.
   function void check_result(logic [31:0] value, logic last_flag, logic dropped);
      sorted_beat_type b;
      if (awaited.size() == 0) begin
         report($sformatf("unexpected beat value %0d", $signed(value)));
         return;
      end
      b = awaited.pop_front();
      if (value !== b.value)
         report($sformatf("value %0d, want %0d", $signed(value), $signed(b.value)));
      if (last_flag !== b.last_flag)
         report($sformatf("last %b, want %b", last_flag, b.last_flag));
      if (dropped !== b.dropped)
         report($sformatf("overflow %b, want %b", dropped, b.dropped));
   endfunction
endclass

module tb_insertion_sorter;
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_value;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_value_res;
   logic        rsp_last_res;
   logic        rsp_overflow;

   sort_scoreboard board = new();
   bit             hold_off;
   bit             sending_done;

   insertion_sorter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value_res(rsp_value_res), .rsp_last_res(rsp_last_res),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Offers one beat and holds it until accepted; an optional gap follows.
   task automatic send_beat(logic [31:0] value, logic last_flag);
      int gap;
      req_valid <= 1;
      req_value <= value;
      req_last  <= last_flag;
      do @(posedge clock); while (req_stall);
      board.note_input(value, last_flag);
      // Start a gap at random, so bursts have random length.
      if ($urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7fff_ffff - $urandom_range(0, 3);
         2: return $urandom_range(0, 7) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_set(int count);
      for (int k = 0; k < count; k++)
         send_beat(random_value(), k == count - 1);
   endtask

   // Stimulus: directed sets first, then random sets.
   initial begin
      int sent;
      int count;
      reset = 1; req_valid = 0; req_value = 0; req_last = 0;
      sending_done = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // A single-value set, then extremes and duplicates in one set.
      send_beat(32'h7fff_ffff, 1);
      send_beat(32'h7fff_ffff, 0);
      send_beat(32'h8000_0000, 0);
      send_beat(32'h0000_0000, 0);
      send_beat(32'hffff_ffff, 0);
      send_beat(32'h8000_0000, 0);
      send_beat(32'h0000_0001, 1);
      // Overflow: eighteen values, the last two discarded, the final one still closing.
      for (int k = 0; k < 18; k++)
         send_beat(32'h5555_5555 ^ (k * 32'h1111_1111), k == 17);
      sent = 25;
      while (sent < 280) begin
         count = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20)
                                             : $urandom_range(1, 8);
         send_set(count);
         sent += count;
      end
      req_valid <= 0;
      sending_done = 1;
   end

   // Receiver stalls on its own pattern, plus one long hold-off.
   initial begin
      hold_off  = 0;
      @(negedge reset);
      repeat (300) @(posedge clock);
      hold_off = 1;
      repeat (60) @(posedge clock);
      hold_off = 0;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1;
      else if (hold_off)
         rsp_stall <= 1;
      else if (($time / 800) % 3 == 0)
         rsp_stall <= 0;
      else
         rsp_stall <= ($urandom_range(0, 2) == 0);
   end

   // Check each accepted output beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_value_res, rsp_last_res, rsp_overflow);
   end

   // Finish once everything expected has arrived.
   initial begin
      wait (sending_done);
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.error_count == 0 && board.open_set.size() == 0)
         $display("tb_insertion_sorter: clean");
      else
         $display("tb_insertion_sorter: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_insertion_sorter: errors");
      $finish;
   end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/isort_pkg.sv
hw/rtl/isort_front.sv
hw/rtl/isort_back.sv
hw/rtl/insertion_sorter.sv
tb/tb_insertion_sorter.sv
